/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion helpers shared by the power block
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* src/ipow_pkg.sv */
// ---------------------------------------------------------------------------
// ipow_pkg
// Widths, defaults and the beat type carried down the power pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipow_pkg;

  // Data word width (base, power)
  localparam int WORD_W = 32;

  // Exponent field width on the input channel
  localparam int EXP_W = 32;

  // Default number of exponent bits scanned
  localparam int EXP_BITS_DEF = 32;

  // One beat in flight: running product, current base power, remaining bits
  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] sq;
    logic [EXP_W-1:0]  exp;
  } ipow_item_t;

endpackage

/* src/ipow_if.sv */
// ---------------------------------------------------------------------------
// ipow channel interfaces
// Valid/ready channels for power requests and power results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipow_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [ipow_pkg::WORD_W-1:0]       base;
  logic        [ipow_pkg::EXP_W-1:0]        exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface ipow_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [ipow_pkg::WORD_W-1:0]       power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

/* src/integer_power_by_squaring.sv */
// ---------------------------------------------------------------------------
// integer_power_by_squaring
// Signed 32-bit base raised to an unsigned exponent, wrapped modulo 2^32.
// ---------------------------------------------------------------------------
// Usage:
//   in_if  : request beats (base, exponent), taken when valid and ready.
//   out_if : result beats (power), taken when valid and ready.
//   Each request yields exactly one result, in request order.
//   The exponent is scanned LSB first, one bit per pipeline stage: each
//   stage squares the running base power and multiplies it into the product
//   when its bit is set. Two 32x32 low-half multipliers per stage.
//   Path: EXP_BITS stages, then the output register.
//   Throughput: one beat per cycle while the skid slot is empty.
//   Stall: a stalled receiver holds the output beat; the next finished beat
//   parks in a skid slot, and only then does in_if.ready drop and the whole
//   pipeline freeze. Nothing is dropped or repeated.
//   Reset (rst_n low, synchronous): all valid bits clear; in-flight beats
//   are discarded. No configuration and no state beyond the pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_power_by_squaring #(
  parameter int EXP_BITS = ipow_pkg::EXP_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ipow_in_if.sink    in_if,
  ipow_out_if.source out_if
);

  logic                 pipe_en;
  logic                 stg_valid [EXP_BITS+1];
  ipow_pkg::ipow_item_t stg_item  [EXP_BITS+1];

  // Entry beat: product starts at one, base power at the base
  assign in_if.ready   = pipe_en;
  assign stg_valid[0]  = in_if.valid;
  assign stg_item[0].acc = {{(ipow_pkg::WORD_W-1){1'b0}}, 1'b1};
  assign stg_item[0].sq  = in_if.base;
  assign stg_item[0].exp = in_if.exponent;

  // One stage per exponent bit
  for (genvar k = 0; k < EXP_BITS; k++) begin : g_stage
    ipow_stage u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (pipe_en),
      .in_valid    (stg_valid[k]),
      .in_item     (stg_item[k]),
      .out_valid_r (stg_valid[k+1]),
      .out_item_r  (stg_item[k+1])
    );
  end

  // Output register and skid slot
  ipow_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (stg_valid[EXP_BITS]),
    .pipe_data  (stg_item[EXP_BITS].acc),
    .pipe_en    (pipe_en),
    .out_if     (out_if)
  );

  // A frozen pipeline keeps its tail beat
  `ASSERT_NEXT(a_tail_holds, !pipe_en && stg_valid[EXP_BITS],
               stg_valid[EXP_BITS] && $stable(stg_item[EXP_BITS].acc))

endmodule

/* src/ipow_stage.sv */
// ---------------------------------------------------------------------------
// ipow_stage
// One bit of right-to-left square-and-multiply: fold the base power into
// the product when the low exponent bit is set, square the base power.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipow_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  ipow_pkg::ipow_item_t in_item,
  output logic                 out_valid_r,
  output ipow_pkg::ipow_item_t out_item_r
);

  logic [ipow_pkg::WORD_W-1:0] acc_mul;
  logic [ipow_pkg::WORD_W-1:0] sq_mul;
  ipow_pkg::ipow_item_t        item_nxt;

  // Two independent low-half products, registered below
  assign acc_mul = in_item.acc * in_item.sq;
  assign sq_mul  = in_item.sq * in_item.sq;

  always_comb begin
    item_nxt.acc = in_item.exp[0] ? acc_mul : in_item.acc;
    item_nxt.sq  = sq_mul;
    item_nxt.exp = {1'b0, in_item.exp[ipow_pkg::EXP_W-1:1]};
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= item_nxt;
    end
  end

  // A clear exponent bit passes the product through untouched
  `ASSERT_NEXT(a_skip_holds_acc, en && in_valid && !in_item.exp[0],
               out_item_r.acc == $past(in_item.acc))
  // Remaining exponent bits only shift down
  `ASSERT_NEXT(a_exp_shifts, en && in_valid,
               out_item_r.exp[ipow_pkg::EXP_W-1] == 1'b0)

endmodule

/* src/ipow_out_buf.sv */
// ---------------------------------------------------------------------------
// ipow_out_buf
// Output register plus skid slot; freezes the pipeline only once the skid
// slot holds a beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipow_out_buf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pipe_valid,
  input  logic [ipow_pkg::WORD_W-1:0] pipe_data,
  output logic                        pipe_en,
  ipow_out_if.source                  out_if
);

  logic                        out_valid_r;
  logic [ipow_pkg::WORD_W-1:0] out_data_r;
  logic                        skid_valid_r;
  logic [ipow_pkg::WORD_W-1:0] skid_data_r;

  // Pipeline moves whenever the skid slot is empty
  assign pipe_en = !skid_valid_r;

  assign out_if.valid = out_valid_r;
  assign out_if.power = out_data_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_if.ready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_if.ready) begin
      out_valid_r <= pipe_valid;
    end else if (pipe_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Data
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_if.ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || out_if.ready) begin
      out_data_r <= pipe_data;
    end else if (pipe_valid) begin
      skid_data_r <= pipe_data;
    end
  end

  // Skid slot is only ever behind a held output beat
  `ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r)
  // A tail beat that meets a held output beat lands in the skid slot
  `ASSERT_NEXT(a_skid_fill, pipe_en && pipe_valid && out_valid_r && !out_if.ready,
               skid_valid_r && out_valid_r)

endmodule
